// ----- sv/ewr_pkg.sv -----
// ----------------------------------------------------------------------------
// ewr_pkg
// Shared constants, lane control bundle and the sample square helper for the
// windowed EMG RMS block.
// ----------------------------------------------------------------------------
package ewr_pkg;

  localparam int unsigned WINDOW   = 20;
  localparam int unsigned CHANNELS = 8;
  localparam int unsigned NUM_OUT  = 8;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned ROOT_W   = 8;
  localparam int unsigned SQ_W     = 15;  // (-128)^2 = 16384

  localparam int unsigned POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W  = $clog2(WINDOW * 16384 + 1);
  localparam int unsigned WIN_W  = $clog2(WINDOW + 1);
  localparam int unsigned SQW_W  = 2 * ROOT_W + WIN_W;  // root^2 * WINDOW
  localparam int unsigned RW_W   = ROOT_W + WIN_W;      // root * WINDOW
  localparam int unsigned BIT_W  = $clog2(ROOT_W);

  typedef struct packed {
    logic              fresh_en;   // capture the incoming sample
    logic              rd_en;      // read the oldest ring entry
    logic              sq_en;      // square old/new, write the ring
    logic              filled;     // ring has wrapped at least once
    logic              sum_en;     // update the running sum
    logic              root_init;  // clear the root iteration
    logic              root_en;    // try one root bit
    logic [BIT_W-1:0]  bit_idx;
    logic [POS_W-1:0]  pos;
  } lane_ctrl_t;

  function automatic logic [SQ_W-1:0] sq8(input logic [SAMPLE_W-1:0] raw);
    logic signed [2*SAMPLE_W-1:0] p;
    p = $signed(raw) * $signed(raw);
    return p[SQ_W-1:0];
  endfunction

endpackage

// ----- sv/ewr_ram.sv -----
// ----------------------------------------------------------------------------
// ewr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ewr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 20,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/ewr_lane.sv -----
// ----------------------------------------------------------------------------
// ewr_lane
// One channel: sample ring, running sum of squares and a bit-per-cycle
// square root of sum / WINDOW.
// ----------------------------------------------------------------------------
module ewr_lane (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ewr_pkg::lane_ctrl_t              ctrl_i,
  input  logic [ewr_pkg::SAMPLE_W-1:0]     fresh_i,
  output logic [ewr_pkg::ROOT_W-1:0]       root_o
);

  logic [ewr_pkg::SAMPLE_W-1:0] fresh_q;
  logic [ewr_pkg::SAMPLE_W-1:0] old_raw;
  logic [ewr_pkg::SAMPLE_W-1:0] old_eff;
  logic [ewr_pkg::SQ_W-1:0]     sq_old_q, sq_new_q;
  logic [ewr_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [ewr_pkg::ROOT_W-1:0]   root_q, root_d;
  logic [ewr_pkg::SQW_W-1:0]    rsqw_q, rsqw_d;
  logic [ewr_pkg::RW_W-1:0]     rw_q, rw_d;
  logic [ewr_pkg::SQW_W-1:0]    trial;
  logic [ewr_pkg::SQW_W-1:0]    win_sqw;
  logic [ewr_pkg::RW_W-1:0]     win_rw;

  ewr_ram #(
    .WIDTH (ewr_pkg::SAMPLE_W),
    .DEPTH (ewr_pkg::WINDOW)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (ctrl_i.sq_en),
    .wr_addr_i (ctrl_i.pos),
    .wr_data_i (fresh_q),
    .rd_en_i   (ctrl_i.rd_en),
    .rd_addr_i (ctrl_i.pos),
    .rd_data_o (old_raw)
  );

  // Entries not yet written since reset read as zero.
  assign old_eff = ctrl_i.filled ? old_raw : '0;

  assign win_sqw = ewr_pkg::SQW_W'(ewr_pkg::WINDOW);
  assign win_rw  = ewr_pkg::RW_W'(ewr_pkg::WINDOW);

  // (root + 2^k)^2 * W = root^2*W + (root*W) << (k+1) + W << 2k
  assign trial = rsqw_q
               + (ewr_pkg::SQW_W'(rw_q) << ({1'b0, ctrl_i.bit_idx} + 1'b1))
               + (win_sqw << {ctrl_i.bit_idx, 1'b0});

  assign sum_d = sum_q - ewr_pkg::SUM_W'(sq_old_q) + ewr_pkg::SUM_W'(sq_new_q);

  always_comb begin
    root_d = root_q;
    rsqw_d = rsqw_q;
    rw_d   = rw_q;
    if (ctrl_i.root_init) begin
      root_d = '0;
      rsqw_d = '0;
      rw_d   = '0;
    end else if (ctrl_i.root_en && (trial <= ewr_pkg::SQW_W'(sum_q))) begin
      root_d = root_q | (ewr_pkg::ROOT_W'(1) << ctrl_i.bit_idx);
      rsqw_d = trial;
      rw_d   = rw_q + (win_rw << ctrl_i.bit_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fresh_en) begin
      fresh_q <= fresh_i;
    end
    if (ctrl_i.sq_en) begin
      sq_old_q <= ewr_pkg::sq8(old_eff);
      sq_new_q <= ewr_pkg::sq8(fresh_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      root_q <= '0;
      rsqw_q <= '0;
      rw_q   <= '0;
    end else begin
      if (ctrl_i.sum_en) begin
        sum_q <= sum_d;
      end
      root_q <= root_d;
      rsqw_q <= rsqw_d;
      rw_q   <= rw_d;
    end
  end

  assign root_o = root_q;

endmodule

// ----- sv/ewr_merge.sv -----
// ----------------------------------------------------------------------------
// ewr_merge
// Gathers the lane roots into one result beat and holds it for the consumer.
// ----------------------------------------------------------------------------
module ewr_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic [ewr_pkg::ROOT_W-1:0]  roots_i [ewr_pkg::NUM_OUT],
  output logic                        free_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ewr_pkg::ROOT_W-1:0]  rms_o [ewr_pkg::NUM_OUT]
);

  logic                       valid_q;
  logic [ewr_pkg::ROOT_W-1:0] rms_q [ewr_pkg::NUM_OUT];

  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rms_q <= roots_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rms_o       = rms_q;

endmodule

// ----- sv/emg_window_rms.sv -----
// ----------------------------------------------------------------------------
// emg_window_rms
// Each accepted beat reads the ring, then passes S_SQ, S_SUM (sum update),
// the 8-step square root every lane runs in S_ROOT (one root bit per cycle)
// and S_DONE; no new sample is taken until the sequencer is back in S_IDLE.
// Reset: asynchronous, active low; sums, ring position and fill flag clear,
// the ring memories are masked by the fill flag until the first wrap.
// ----------------------------------------------------------------------------
module emg_window_rms (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] emg_ch0_i,
  input  logic [7:0] emg_ch1_i,
  input  logic [7:0] emg_ch2_i,
  input  logic [7:0] emg_ch3_i,
  input  logic [7:0] emg_ch4_i,
  input  logic [7:0] emg_ch5_i,
  input  logic [7:0] emg_ch6_i,
  input  logic [7:0] emg_ch7_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] rms_ch0_o,
  output logic [7:0] rms_ch1_o,
  output logic [7:0] rms_ch2_o,
  output logic [7:0] rms_ch3_o,
  output logic [7:0] rms_ch4_o,
  output logic [7:0] rms_ch5_o,
  output logic [7:0] rms_ch6_o,
  output logic [7:0] rms_ch7_o
);

  // Sequencer: accept, square/write ring, update sums, root bits, hand off.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_SUM,
    S_ROOT,
    S_DONE
  } state_e;

  state_e                       state_q;
  logic [ewr_pkg::BIT_W-1:0]    bit_q;
  logic [ewr_pkg::POS_W-1:0]    pos_q;
  logic                         filled_q;

  logic                         accept;
  logic                         merge_free;
  logic                         load;
  ewr_pkg::lane_ctrl_t          ctrl;

  logic [ewr_pkg::SAMPLE_W-1:0] samples [ewr_pkg::NUM_OUT];
  logic [ewr_pkg::ROOT_W-1:0]   roots   [ewr_pkg::NUM_OUT];
  logic [ewr_pkg::ROOT_W-1:0]   rms     [ewr_pkg::NUM_OUT];

  assign samples[0] = emg_ch0_i;
  assign samples[1] = emg_ch1_i;
  assign samples[2] = emg_ch2_i;
  assign samples[3] = emg_ch3_i;
  assign samples[4] = emg_ch4_i;
  assign samples[5] = emg_ch5_i;
  assign samples[6] = emg_ch6_i;
  assign samples[7] = emg_ch7_i;

  // Take a new beat only between items; the output register lets a new
  // sample start while the previous result still waits downstream.
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign load       = (state_q == S_DONE) && merge_free;

  // Control bundle broadcast to every lane.
  always_comb begin
    ctrl           = '0;
    ctrl.fresh_en  = accept;
    ctrl.rd_en     = accept;
    ctrl.sq_en     = (state_q == S_SQ);
    ctrl.filled    = filled_q;
    ctrl.sum_en    = (state_q == S_SUM);
    ctrl.root_init = (state_q == S_SUM);
    ctrl.root_en   = (state_q == S_ROOT);
    ctrl.bit_idx   = bit_q;
    ctrl.pos       = pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      bit_q    <= '0;
      pos_q    <= '0;
      filled_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          // Ring write happens this cycle; advance the shared position.
          if (pos_q == ewr_pkg::POS_W'(ewr_pkg::WINDOW - 1)) begin
            pos_q    <= '0;
            filled_q <= 1'b1;
          end else begin
            pos_q <= pos_q + 1'b1;
          end
          state_q <= S_SUM;
        end
        S_SUM: begin
          bit_q   <= ewr_pkg::BIT_W'(ewr_pkg::ROOT_W - 1);
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          if (bit_q == '0) begin
            state_q <= S_DONE;
          end else begin
            bit_q <= bit_q - 1'b1;
          end
        end
        S_DONE: begin
          // Hold until the output register can take the beat.
          if (merge_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // One lane per active channel; unused channels report zero.
  for (genvar g = 0; g < ewr_pkg::NUM_OUT; g++) begin : g_lane
    if (g < ewr_pkg::CHANNELS) begin : g_on
      ewr_lane u_lane (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .fresh_i (samples[g]),
        .root_o  (roots[g])
      );
    end else begin : g_off
      assign roots[g] = '0;
    end
  end

  ewr_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .roots_i     (roots),
    .free_o      (merge_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rms_o       (rms)
  );

  assign rms_ch0_o = rms[0];
  assign rms_ch1_o = rms[1];
  assign rms_ch2_o = rms[2];
  assign rms_ch3_o = rms[3];
  assign rms_ch4_o = rms[4];
  assign rms_ch5_o = rms[5];
  assign rms_ch6_o = rms[6];
  assign rms_ch7_o = rms[7];

endmodule

// ----- tb/sv/emg_window_rms_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emg_window_rms_tb
// Self-checking bench for the windowed EMG RMS block. A table of directed
// samples covers reset, warm-up and the most negative sample. Random samples
// follow under several sender and receiver idling mixes, including one long
// receiver hold that backs the pipe up. Every result beat is checked lane by
// lane against an in-bench model of the ring, the running sums of squares
// and the floored square root, or against its directed row's value if typed.
// ----------------------------------------------------------------------------
module emg_window_rms_tb;

  typedef logic [ewr_pkg::NUM_OUT-1:0][7:0] lane_bytes_t;

  // One directed row: a sample repeated reps times; when typed is set the
  // last repeat expects rms_all on every lane.
  typedef struct packed {
    lane_bytes_t smp;
    logic [7:0]  reps;
    logic        typed;
    logic [7:0]  rms_all;
  } dir_row_t;

  localparam int N_DIR_ROWS  = 8;
  localparam int N_RAND      = 825;
  localparam int N_PHASES    = 5;
  localparam int PHASE_PRESS = 4;
  localparam int HOLD_CYC    = 400;
  localparam int DRAIN_CYC   = 30;

  localparam dir_row_t DIR_TAB [N_DIR_ROWS] = '{
    // all zero right after reset
    '{smp: '0,                    reps: 8'd1,  typed: 1'b1, rms_all: 8'd0},
    // first -128: sqrt(16384 / 20) floors to 28 during warm-up
    '{smp: {8{8'h80}},            reps: 8'd1,  typed: 1'b1, rms_all: 8'd28},
    '{smp: {8{8'h80}},            reps: 8'd18, typed: 1'b0, rms_all: 8'd0},
    // window now holds only -128
    '{smp: {8{8'h80}},            reps: 8'd1,  typed: 1'b1, rms_all: 8'd128},
    '{smp: {8{8'h7F}},            reps: 8'd1,  typed: 1'b0, rms_all: 8'd0},
    '{smp: {4{8'hAA, 8'h55}},     reps: 8'd1,  typed: 1'b0, rms_all: 8'd0},
    '{smp: {8'h10, 8'hC0, 8'h40, 8'h00, 8'h80, 8'h7F, 8'hFF, 8'h01},
                                  reps: 8'd1,  typed: 1'b0, rms_all: 8'd0},
    '{smp: {8{8'hFF}},            reps: 8'd1,  typed: 1'b0, rms_all: 8'd0}
  };

  localparam int IDLE_IN   [N_PHASES] = '{0, 49, 0, 11, 0};
  localparam int STALL_OUT [N_PHASES] = '{0, 0, 49, 11, 0};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  lane_bytes_t samp_bus    = '0;
  lane_bytes_t rms_bus;

  // Sideband that travels with each input beat: a typed expectation.
  logic        beat_typed  = 1'b0;
  logic [7:0]  beat_rms    = '0;

  logic        hold_req    = 1'b0;
  int          idle_pct    = 0;
  int          stall_pct   = 0;

  // In-bench copy of the block state.
  logic [7:0]  hist   [ewr_pkg::WINDOW][ewr_pkg::NUM_OUT] = '{default: '0};
  int          energy [ewr_pkg::NUM_OUT]                  = '{default: 0};
  int          slot                                       = 0;

  lane_bytes_t rms_q [$];
  int          n_checked  = 0;
  int          n_errors   = 0;
  int          n_peak     = 0;
  int          n_accepted = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  emg_window_rms DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .emg_ch0_i   (samp_bus[0]),
    .emg_ch1_i   (samp_bus[1]),
    .emg_ch2_i   (samp_bus[2]),
    .emg_ch3_i   (samp_bus[3]),
    .emg_ch4_i   (samp_bus[4]),
    .emg_ch5_i   (samp_bus[5]),
    .emg_ch6_i   (samp_bus[6]),
    .emg_ch7_i   (samp_bus[7]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rms_ch0_o   (rms_bus[0]),
    .rms_ch1_o   (rms_bus[1]),
    .rms_ch2_o   (rms_bus[2]),
    .rms_ch3_o   (rms_bus[3]),
    .rms_ch4_o   (rms_bus[4]),
    .rms_ch5_o   (rms_bus[5]),
    .rms_ch6_o   (rms_bus[6]),
    .rms_ch7_o   (rms_bus[7])
  );

  // Largest r in 0..255 with r*r <= x, one bit at a time from the top.
  function automatic logic [7:0] floor_root(input int x);
    int r;
    int t;
    r = 0;
    for (int b = 7; b >= 0; b--) begin
      t = r | (1 << b);
      if (t * t <= x) r = t;
    end
    return r[7:0];
  endfunction

  // Push one sample into the window model and return the RMS of every lane.
  function automatic lane_bytes_t advance_window(input lane_bytes_t smp);
    lane_bytes_t r;
    int          v_old;
    int          v_new;
    r = '0;
    for (int ch = 0; ch < ewr_pkg::NUM_OUT; ch++) begin
      if (ch < ewr_pkg::CHANNELS) begin
        v_old = int'($signed(hist[slot][ch]));
        v_new = int'($signed(smp[ch]));
        energy[ch] = energy[ch] - v_old * v_old + v_new * v_new;
        hist[slot][ch] = smp[ch];
        r[ch] = floor_root(energy[ch] / ewr_pkg::WINDOW);
      end
    end
    slot = (slot == ewr_pkg::WINDOW - 1) ? 0 : slot + 1;
    return r;
  endfunction

  // Random sample: full-scale noise half the time, else small resting signal,
  // rail values, bursts and repeated samples.
  function automatic lane_bytes_t rand_sample(input lane_bytes_t prev);
    lane_bytes_t s;
    int          mode;
    int          mag;
    mode = $urandom_range(9);
    for (int ch = 0; ch < ewr_pkg::NUM_OUT; ch++) begin
      case (mode) inside
        5, 6: begin
          s[ch] = 8'($urandom_range(24) - 12);
        end
        7: begin
          case ($urandom_range(3))
            0:       s[ch] = 8'h80;
            1:       s[ch] = 8'h7F;
            2:       s[ch] = 8'h00;
            default: s[ch] = 8'hFF;
          endcase
        end
        8: begin
          s[ch] = prev[ch];
        end
        9: begin
          mag   = $urandom_range(100, 128);
          s[ch] = $urandom_range(1) ? 8'(-mag) : 8'(mag > 127 ? 127 : mag);
        end
        default: begin
          s[ch] = 8'($urandom);
        end
      endcase
    end
    return s;
  endfunction

  // Idle the sender cycle by cycle at idle_pct, then offer one beat and
  // hold it until accepted. Call only right after a rising edge.
  task automatic offer_beat(input lane_bytes_t s, input logic typed,
                            input logic [7:0] rms_all);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    samp_bus   <= s;
    beat_typed <= typed;
    beat_rms   <= rms_all;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Receiver: random stall per cycle, or one long counted hold on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req    <= 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYC - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Predict on every accepted input beat, check every accepted result beat.
  always @(posedge clk_i) begin
    lane_bytes_t pred;
    lane_bytes_t want;
    if (in_valid_i && !in_stall_o) begin
      pred = advance_window(samp_bus);
      n_accepted++;
      // a typed row carries its own value on every lane
      rms_q.push_back(beat_typed ? {ewr_pkg::NUM_OUT{beat_rms}} : pred);
    end
    if (out_valid_o && !out_stall_i) begin
      if (rms_q.size() == 0) begin
        $error("result beat with no sample waiting");
        n_errors++;
      end else begin
        want = rms_q.pop_front();
        n_checked++;
        for (int k = 0; k < ewr_pkg::NUM_OUT; k++) begin
          if (rms_bus[k] !== want[k]) begin
            $error("rms_ch%0d: expected %0d, got %0d", k, want[k], rms_bus[k]);
            n_errors++;
          end
          if (rms_bus[k] == 8'd128) n_peak++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain, verdict.
  initial begin
    lane_bytes_t s;
    int          per_phase;
    s         = '0;
    per_phase = N_RAND / N_PHASES;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int row = 0; row < N_DIR_ROWS; row++) begin
      for (int rep = 0; rep < int'(DIR_TAB[row].reps); rep++) begin
        offer_beat(DIR_TAB[row].smp,
                   DIR_TAB[row].typed && (rep == int'(DIR_TAB[row].reps) - 1),
                   DIR_TAB[row].rms_all);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      idle_pct  = IDLE_IN[ph];
      stall_pct = STALL_OUT[ph];
      // back the pipe up: the receiver holds while samples keep coming
      if (ph == PHASE_PRESS) hold_req <= 1'b1;
      for (int n = 0; n < per_phase; n++) begin
        s = rand_sample(s);
        offer_beat(s, 1'b0, 8'd0);
      end
    end
    in_valid_i <= 1'b0;
    stall_pct = 0;

    while (rms_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("covered %0d samples (directed warm-up and full -128 window, then random)",
             n_accepted);
    $display("checked %0d results, %0d lanes at full scale, %0d mismatches",
             n_checked, n_peak, n_errors);
    if (n_errors == 0) begin
      $display("emg_window_rms_tb passed");
    end else begin
      $display("emg_window_rms_tb failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("emg_window_rms_tb failed");
    $finish;
  end

endmodule

// ----- files.f -----
sv/ewr_pkg.sv
sv/ewr_ram.sv
sv/ewr_lane.sv
sv/ewr_merge.sv
sv/emg_window_rms.sv
tb/sv/emg_window_rms_tb.sv
